// File: design/swm_pkg.sv
// Shared types and constants for the sliding window median filter.
package swm_pkg;

  localparam int CFG_WIDTH = 7;
  localparam logic [CFG_WIDTH-1:0] WINDOW_RESET = 7'd3;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_CLEAR_INSERT,
    OP_REMOVE
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SUM,
    ST_DROP
  } swm_state_t;

  // Status that each cell shows to its neighbours.
  typedef struct packed {
    logic valid;
    logic after;
    logic eq;
  } cell_link_t;

endpackage

// File: design/swm_in_if.sv
// Input channel: one sample and its start flag per transfer.
interface swm_in_if #(
  parameter int SAMPLE_BITS = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          start_of_sequence;

  modport source (output valid, output sample, output start_of_sequence, input ready);
  modport sink (input valid, input sample, input start_of_sequence, output ready);
endinterface

// File: design/swm_out_if.sv
// Result channel: twice the window median per transfer.
interface swm_out_if #(
  parameter int SAMPLE_BITS = 32
);
  logic                        valid;
  logic                        ready;
  logic signed [SAMPLE_BITS:0] median_doubled;

  modport source (output valid, output median_doubled, input ready);
  modport sink (input valid, input median_doubled, output ready);
endinterface

// File: design/swm_cell.sv
// One cell of the sorted window: holds a sample and shifts with its neighbours.
module swm_cell #(
  parameter int SAMPLE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  swm_pkg::cell_op_t             op,
  input  logic signed [SAMPLE_BITS-1:0] key,
  input  logic signed [SAMPLE_BITS-1:0] left_value,
  input  swm_pkg::cell_link_t           left_link,
  input  logic signed [SAMPLE_BITS-1:0] right_value,
  input  swm_pkg::cell_link_t           right_link,
  output logic signed [SAMPLE_BITS-1:0] value,
  output swm_pkg::cell_link_t           link
);
  import swm_pkg::*;

  logic signed [SAMPLE_BITS-1:0] value_r, value_nxt;
  logic                          valid_r, valid_nxt;
  logic                          gt;
  logic                          take_right;

  assign gt = valid_r && (value_r > key);

  assign link.valid = valid_r;
  assign link.after = !valid_r || gt;
  assign link.eq    = valid_r && (value_r == key);

  // The last copy of an equal run leaves; larger samples close the gap.
  assign take_right = valid_r && (gt || (link.eq && !right_link.eq));

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    case (op)
      OP_INSERT: begin
        if (link.after) begin
          if (left_link.after) begin
            value_nxt = left_value;
            valid_nxt = left_link.valid;
          end else begin
            value_nxt = key;
            valid_nxt = 1'b1;
          end
        end
      end
      OP_CLEAR_INSERT: begin
        // A real cell always shows itself as present or after the key, so only
        // the first cell, whose left edge shows neither, keeps the sample.
        value_nxt = key;
        valid_nxt = !left_link.valid && !left_link.after;
      end
      OP_REMOVE: begin
        if (take_right) begin
          value_nxt = right_value;
          valid_nxt = right_link.valid;
        end
      end
      default: begin
        value_nxt = value_r;
        valid_nxt = valid_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;

endmodule

// File: design/sliding_window_median.sv
// Top level of the sliding window median filter.
//
// Samples arrive on in_ch, one per transfer, with a start flag that empties
// the window before the sample is taken. Each sample is written to an arrival
// ring and inserted into a chain of cells that keeps the window sorted. Once
// the window holds window_size samples, twice the median leaves on out_ch and
// the oldest sample is removed from the chain by value.
// window_size is written through cfg_we and cfg_wdata; the user must write it
// only while the block is idle, which the block does not enforce. Zero acts
// as one and values above MAX_WINDOW saturate. An item with no result goes
// through insert and check; one with a result through insert, check, median,
// remove and check; each sample dropped after window_size is lowered adds
// remove and check. No new sample is taken until the steps end; they follow
// from the cell chain's insert and remove and the registered ring read of the
// oldest sample. The result passes the median tap and output registers. Reset
// empties the window and sets window_size to 3. A stalled receiver holds the
// result in the output register; the block then waits in its median step.
module sliding_window_median #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  swm_in_if.sink                          in_ch,
  swm_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [swm_pkg::CFG_WIDTH-1:0]   cfg_wdata
);
  import swm_pkg::*;

  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WW = (CW > CFG_WIDTH) ? CW : CFG_WIDTH;

  swm_state_t state_r, state_nxt;

  logic [CFG_WIDTH-1:0]          cfg_window_r;
  logic [WW-1:0]                 cfg_wide;
  logic [CW-1:0]                 win_eff;
  logic [CW-1:0]                 hi_idx;
  logic [CW-1:0]                 lo_idx;

  logic [CW-1:0]                 count_r, count_nxt;
  logic [IW-1:0]                 oldest_r, oldest_nxt;
  logic [CW-1:0]                 base_count;
  logic [CW:0]                   slot_sum;
  logic [IW-1:0]                 slot;

  logic [SAMPLE_BITS-1:0]        ring_mem [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] oldest_val_r;

  logic signed [SAMPLE_BITS-1:0] lo_r, hi_r, lo_sel, hi_sel;
  logic                          odd_r;

  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS:0]   out_data_r, out_data_nxt;

  logic                          accept;
  logic                          out_free;
  logic                          ring_we;
  logic                          eval_load;
  logic                          sum_load;
  cell_op_t                      cell_op;
  logic signed [SAMPLE_BITS-1:0] cell_key;

  cell_link_t                    cell_link  [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] cell_value [MAX_WINDOW];

  // Effective window: zero acts as one, large values saturate.
  always_comb begin
    cfg_wide = WW'(cfg_window_r);
    if (cfg_wide == '0) begin
      win_eff = CW'(1);
    end else if (cfg_wide > WW'(MAX_WINDOW)) begin
      win_eff = CW'(MAX_WINDOW);
    end else begin
      win_eff = CW'(cfg_wide);
    end
  end

  assign hi_idx = win_eff >> 1;
  assign lo_idx = hi_idx - CW'(1);

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (count_r > win_eff) begin
          state_nxt = ST_DROP;
        end else if (count_r == win_eff) begin
          state_nxt = ST_SUM;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SUM: begin
        if (out_free) begin
          state_nxt = ST_DROP;
        end
      end
      ST_DROP: begin
        state_nxt = ST_EVAL;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_ch.ready = 1'b0;
    ring_we     = 1'b0;
    eval_load   = 1'b0;
    sum_load    = 1'b0;
    cell_op     = OP_HOLD;
    cell_key    = oldest_val_r;
    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        cell_key    = in_ch.sample;
        if (accept) begin
          ring_we = 1'b1;
          cell_op = in_ch.start_of_sequence ? OP_CLEAR_INSERT : OP_INSERT;
        end
      end
      ST_EVAL: begin
        eval_load = 1'b1;
      end
      ST_SUM: begin
        sum_load = out_free;
      end
      ST_DROP: begin
        cell_op = OP_REMOVE;
      end
      default: begin
        cell_op = OP_HOLD;
      end
    endcase
  end

  // Ring slot of the incoming sample.
  assign base_count = in_ch.start_of_sequence ? '0 : count_r;
  always_comb begin
    slot_sum = (CW+1)'(in_ch.start_of_sequence ? '0 : oldest_r) + (CW+1)'(base_count);
    if (slot_sum >= (CW+1)'(MAX_WINDOW)) begin
      slot = IW'(slot_sum - (CW+1)'(MAX_WINDOW));
    end else begin
      slot = IW'(slot_sum);
    end
  end

  // Fill count and oldest pointer.
  always_comb begin
    count_nxt  = count_r;
    oldest_nxt = oldest_r;
    if (ring_we) begin
      count_nxt = base_count + CW'(1);
      if (in_ch.start_of_sequence) begin
        oldest_nxt = '0;
      end
    end else if (cell_op == OP_REMOVE) begin
      count_nxt = count_r - CW'(1);
      if (oldest_r == IW'(MAX_WINDOW - 1)) begin
        oldest_nxt = '0;
      end else begin
        oldest_nxt = oldest_r + IW'(1);
      end
    end
  end

  // Median taps: each cell is selected by its fixed position.
  always_comb begin
    lo_sel = '0;
    hi_sel = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      if (hi_idx == CW'(i)) begin
        hi_sel = hi_sel | cell_value[i];
      end
      if (lo_idx == CW'(i)) begin
        lo_sel = lo_sel | cell_value[i];
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (sum_load) begin
      out_valid_nxt = 1'b1;
      if (odd_r) begin
        out_data_nxt = {hi_r, 1'b0};
      end else begin
        out_data_nxt = {lo_r[SAMPLE_BITS-1], lo_r} + {hi_r[SAMPLE_BITS-1], hi_r};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cfg_window_r <= WINDOW_RESET;
      count_r      <= '0;
      oldest_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      oldest_r    <= oldest_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cfg_window_r <= cfg_wdata;
      end
    end
  end

  // Arrival ring: written on an input transfer, read while checking the count.
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[slot] <= in_ch.sample;
    end
    if (eval_load) begin
      oldest_val_r <= ring_mem[oldest_r];
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (eval_load) begin
      lo_r  <= lo_sel;
      hi_r  <= hi_sel;
      odd_r <= win_eff[0];
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.median_doubled = out_data_r;

  // The sorted chain. The ends see an empty neighbour.
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] left_value, right_value;
    cell_link_t                    left_link, right_link;

    if (i == 0) begin : g_first
      assign left_value = '0;
      assign left_link  = '{valid: 1'b0, after: 1'b0, eq: 1'b0};
    end else begin : g_mid_left
      assign left_value = cell_value[i-1];
      assign left_link  = cell_link[i-1];
    end

    if (i == MAX_WINDOW - 1) begin : g_last
      assign right_value = '0;
      assign right_link  = '{valid: 1'b0, after: 1'b1, eq: 1'b0};
    end else begin : g_mid_right
      assign right_value = cell_value[i+1];
      assign right_link  = cell_link[i+1];
    end

    swm_cell #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .op          (cell_op),
      .key         (cell_key),
      .left_value  (left_value),
      .left_link   (left_link),
      .right_value (right_value),
      .right_link  (right_link),
      .value       (cell_value[i]),
      .link        (cell_link[i])
    );
  end

endmodule

// File: design/swm_checker.sv
// Port checker for the sliding window median filter and its bind.
module swm_checker #(
  parameter int SAMPLE_BITS = 32
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [SAMPLE_BITS:0]    out_data
);

  // A result that waits keeps its valid.
  a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result valid dropped while stalled");

  // A result that waits keeps its value.
  a_out_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_data))
    else $error("result changed while stalled");

  // Ready drops after each input transfer.
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken in the cycle after a transfer");

  // Reset leaves no result pending.
  a_reset_clears_output: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sliding_window_median swm_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_swm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.median_doubled)
);

// File: sim/sliding_window_median_test.sv
// Self-checking testbench for the sliding window median filter.
module sliding_window_median_test;

  typedef logic signed [31:0] sample_t;
  typedef logic signed [32:0] median_t;

  localparam sample_t SAMPLE_MAX  = 32'sh7FFF_FFFF;
  localparam sample_t SAMPLE_MIN  = 32'sh8000_0000;
  // Cycles without any transfer before the run is declared hung. The slowest
  // legal gap is a window dropping from 64 samples to one.
  localparam int      STALL_LIMIT = 1000;
  // Quiet cycles after the last result, covering the check step that follows.
  localparam int      SETTLE      = 16;

  // Keeps its own copy of the window, in arrival order and in ascending order,
  // and predicts the doubled median for every accepted sample that fills the window.
  class median_scoreboard;
    localparam int WINDOW_LIMIT = 64;

    logic [6:0] window_setting;
    sample_t    arrivals[$];
    sample_t    ranked[$];
    median_t    median_due[$];
    int         mismatches;

    function new();
      window_setting = swm_pkg::WINDOW_RESET;
      mismatches     = 0;
    endfunction

    function void set_window(logic [6:0] value);
      window_setting = value;
    endfunction

    // Zero behaves as a window of one; anything above the limit saturates.
    function int window_length();
      if (window_setting == 7'd0) return 1;
      if (int'(window_setting) > WINDOW_LIMIT) return WINDOW_LIMIT;
      return int'(window_setting);
    endfunction

    // The oldest sample leaves; one copy of its value goes from the ranking.
    function void retire_oldest();
      sample_t gone;
      int      pos;
      gone = arrivals.pop_front();
      pos  = 0;
      while (pos < ranked.size() && ranked[pos] != gone) pos++;
      if (pos < ranked.size()) ranked.delete(pos);
    endfunction

    function void note_sample(sample_t value, logic restart);
      int      span;
      int      pos;
      sample_t lo;
      sample_t hi;
      median_t twice;
      span = window_length();
      if (restart) begin
        arrivals.delete();
        ranked.delete();
      end
      arrivals.push_back(value);
      // A new sample goes after any equal values already held.
      pos = 0;
      while (pos < ranked.size() && ranked[pos] <= value) pos++;
      ranked.insert(pos, value);
      // After the window has been shrunk, surplus samples go without a result.
      while (arrivals.size() > span) retire_oldest();
      if (arrivals.size() == span) begin
        if (span % 2 == 1) begin
          twice = {ranked[span / 2], 1'b0};
        end else begin
          lo    = ranked[span / 2 - 1];
          hi    = ranked[span / 2];
          twice = {lo[31], lo} + {hi[31], hi};
        end
        median_due.push_back(twice);
        retire_oldest();
      end
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      mismatches++;
    endtask

    task check_median(median_t got);
      median_t want;
      if (median_due.size() == 0) begin
        report($sformatf("median %0d arrived with nothing outstanding", got));
      end else begin
        want = median_due.pop_front();
        if (got !== want)
          report($sformatf("median_doubled got %0d, expected %0d", got, want));
      end
    endtask
  endclass

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [6:0]       cfg_wdata;
  // When set, neither side inserts idle cycles, giving a back-to-back stretch.
  bit               steady;
  median_scoreboard sb;

  swm_in_if  #(.SAMPLE_BITS(32)) in_ch ();
  swm_out_if #(.SAMPLE_BITS(32)) out_ch ();

  sliding_window_median #(
    .MAX_WINDOW (64),
    .SAMPLE_BITS(32)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The receiver holds ready low at random, with a chance of 18 percent. Ready changes
  // on the falling edge so that it is settled by the sampling edge.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= steady || ($urandom_range(99) >= 18);
    end
  end

  // Every result transfer is checked against the oldest outstanding median.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_median(out_ch.median_doubled);
  end

  // Watchdog: any transfer on either channel restarts the count, so only a
  // genuine hang, or a result that never comes, trips it.
  initial begin
    int stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        stall = 0;
      else
        stall++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // A quarter of samples are small so that duplicates are common, a tenth are
  // the extremes, zero or minus one, and the rest cover the whole 32-bit range.
  function automatic sample_t pick_sample();
    int roll;
    roll = $urandom_range(99);
    if (roll < 25) return sample_t'(int'($urandom_range(16)) - 8);
    if (roll < 35) begin
      case ($urandom_range(3))
        0:       return SAMPLE_MAX;
        1:       return SAMPLE_MIN;
        2:       return sample_t'(0);
        default: return sample_t'(-1);
      endcase
    end
    return sample_t'($urandom);
  endfunction

  // Presents one sample and holds it until the transfer happens. Valid is
  // left high afterwards, so a following sample goes back to back; the next
  // task to run decides at the falling edge whether it stays high.
  task automatic send_sample(sample_t value, logic restart);
    int gap;
    @(negedge clk);
    if (!steady && $urandom_range(99) < 18) begin
      in_ch.valid <= 1'b0;
      gap = $urandom_range(1, 3);
      repeat (gap) @(negedge clk);
    end
    in_ch.valid             <= 1'b1;
    in_ch.sample            <= value;
    in_ch.start_of_sequence <= restart;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_sample(value, restart);
  endtask

  // Drops valid and waits until every predicted median has been transferred,
  // then lets the block finish any step still under way.
  task automatic wait_drained(int settle);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.median_due.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_window(logic [6:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    sb.set_window(value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [6:0] plan [9];
    logic [6:0] setting;
    int         count;
    logic       restart;

    plan = '{7'd1, 7'd64, 7'd1, 7'd0, 7'd127, 7'd2, 7'd5, 7'd4, 7'd9};
    sb   = new();

    rst_n                   = 1'b0;
    cfg_we                  = 1'b0;
    cfg_wdata               = '0;
    steady                  = 1'b0;
    in_ch.valid             = 1'b0;
    in_ch.sample            = '0;
    in_ch.start_of_sequence = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset window of three: the sample extremes, a
    // restart in mid-window and a run of equal values.
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(sample_t'(0), 1'b0);
    send_sample(sample_t'(-1), 1'b0);
    send_sample(sample_t'(1), 1'b0);
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b1);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(sample_t'(5), 1'b1);
    send_sample(sample_t'(5), 1'b0);
    send_sample(sample_t'(5), 1'b0);
    send_sample(sample_t'(5), 1'b0);
    send_sample(sample_t'(-7), 1'b0);

    // An even window sums the two middle values, so the extremes reach both
    // ends of the 33-bit result.
    wait_drained(SETTLE);
    write_window(7'd2);
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(sample_t'(-1), 1'b0);
    send_sample(sample_t'(0), 1'b1);

    // Random phases. The window is not cleared between phases unless a
    // restart is drawn, so shrinking it drops held samples without a result
    // and growing it delays the next one. Zero and 127 check the clamping.
    for (int p = 0; p < 12; p++) begin
      setting = (p < 9) ? plan[p] : 7'($urandom_range(1, 16));
      wait_drained(SETTLE);
      steady = (p == 1) || (p == 5);
      write_window(setting);
      count = (sb.window_length() >= 32) ? 110 : 30;
      for (int k = 0; k < count; k++) begin
        // Now and then the sender holds off until the pipeline has emptied.
        if (k == count / 2 && (p == 1 || p == 6)) wait_drained(0);
        restart = (k == 0) ? ($urandom_range(2) == 0) : ($urandom_range(99) < 3);
        send_sample(pick_sample(), restart);
      end
    end

    wait_drained(SETTLE);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
